/* src/mrsp_pkg.sv */
package mrsp_pkg;

    // Queue geometry shared by the command queue and the result queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Byte classes produced by the front end
    localparam logic [2:0] K_DATA       = 3'd0; // data byte, bit 7 clear
    localparam logic [2:0] K_CLEAR_EMIT = 3'd1; // reset / active sense
    localparam logic [2:0] K_EMIT       = 3'd2; // real-time and tune request
    localparam logic [2:0] K_STAT_TWO   = 3'd3; // status with two data bytes
    localparam logic [2:0] K_STAT_ONE   = 3'd4; // status with one data byte
    localparam logic [2:0] K_CLEAR      = 3'd5; // other system bytes, silent clear

    // Parser phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_ONE    = 2'd1;
    localparam logic [1:0] PH_FIRST  = 2'd2;
    localparam logic [1:0] PH_SECOND = 2'd3;

    // Message lengths
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] rx_byte;
    } t_cmd;

    // Command channel between front and back
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_chan;

    typedef struct packed {
        logic [1:0] length;
        logic [7:0] status;
        logic [6:0] first_data;
        logic [6:0] second_data;
    } t_result;

    function automatic logic [2:0] classify(input logic [7:0] b);
        logic [2:0] k;
        if (!b[7]) begin
            k = K_DATA;
        end else if (b inside {8'hFF, 8'hFE}) begin
            k = K_CLEAR_EMIT;
        end else if (b inside {8'hF8, 8'hFA, 8'hFB, 8'hFC, 8'hF6}) begin
            k = K_EMIT;
        end else if (b == 8'hF2) begin
            k = K_STAT_TWO;
        end else if (b == 8'hF3) begin
            k = K_STAT_ONE;
        end else if (b[7:4] == 4'hF) begin
            k = K_CLEAR;
        end else if (b[7:4] inside {4'hC, 4'hD}) begin
            k = K_STAT_ONE;
        end else begin
            k = K_STAT_TWO;
        end
        return k;
    endfunction

endpackage

/* src/mrsp_front.sv */
module mrsp_front
    import mrsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  logic [7:0] i_rx_byte,
    output t_cmd_chan o_chan,
    input  logic      i_take
);

    t_cmd                r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic [Q_CNT_W-1:0]  n_count;
    logic                push_ok;
    logic                pop_ok;

    assign full    = (r_count == Q_CNT_W'(Q_DEPTH));
    assign push_ok = push && !full;
    assign pop_ok  = i_take && (r_count != '0);

    assign o_chan.valid = (r_count != '0);
    assign o_chan.cmd   = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // classify on the way in
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= '{kind: classify(i_rx_byte), rx_byte: i_rx_byte};
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("command queue count out of range");

    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_ok && r_count == '0) |=> o_chan.valid)
        else $error("transfer into empty command queue not visible");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 && !push_ok) |=> !o_chan.valid)
        else $error("command queue shows entry without transfer");

endmodule

/* src/mrsp_back.sv */
module mrsp_back
    import mrsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd_chan  i_chan,
    output logic       o_take,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_msg_length,
    output logic [7:0] o_msg_status,
    output logic [6:0] o_msg_first_data,
    output logic [6:0] o_msg_second_data
);

    logic [1:0]          r_phase;
    logic [7:0]          r_running;
    logic [6:0]          r_held_first;
    logic [6:0]          r_held_second;
    logic [1:0]          n_phase;
    logic [7:0]          n_running;
    logic [6:0]          n_held_first;
    logic [6:0]          n_held_second;
    logic                emit;
    t_result             res;

    t_result             r_res [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic [Q_CNT_W-1:0]  n_count;
    logic                pop_ok;
    logic                push_ok;
    logic [6:0]          data;

    assign empty  = (r_count == '0);
    assign pop_ok = pop && !empty;
    // room in the result queue, counting a pop in the same cycle
    assign o_take = i_chan.valid && ((r_count != Q_CNT_W'(Q_DEPTH)) || pop_ok);
    assign data   = i_chan.cmd.rx_byte[6:0];

    always_comb begin
        n_phase       = r_phase;
        n_running     = r_running;
        n_held_first  = r_held_first;
        n_held_second = r_held_second;
        emit          = 1'b0;
        res           = '0;
        case (i_chan.cmd.kind)
            K_CLEAR_EMIT: begin
                n_phase    = PH_IDLE;
                n_running  = '0;
                emit       = 1'b1;
                res.length = LEN_ONE;
                res.status = i_chan.cmd.rx_byte;
            end
            K_EMIT: begin
                emit       = 1'b1;
                res.length = LEN_ONE;
                res.status = i_chan.cmd.rx_byte;
            end
            K_STAT_TWO: begin
                n_phase   = PH_FIRST;
                n_running = i_chan.cmd.rx_byte;
            end
            K_STAT_ONE: begin
                n_phase   = PH_ONE;
                n_running = i_chan.cmd.rx_byte;
            end
            K_CLEAR: begin
                n_phase   = PH_IDLE;
                n_running = '0;
            end
            K_DATA: begin
                case (r_phase)
                    PH_ONE: begin
                        n_held_first    = data;
                        emit            = 1'b1;
                        res.length      = LEN_TWO;
                        res.status      = r_running;
                        res.first_data  = data;
                        res.second_data = r_held_second;
                    end
                    PH_FIRST: begin
                        n_held_first = data;
                        n_phase      = PH_SECOND;
                    end
                    PH_SECOND: begin
                        n_held_second   = data;
                        n_phase         = PH_FIRST;
                        emit            = 1'b1;
                        res.length      = LEN_THREE;
                        res.status      = r_running;
                        res.first_data  = r_held_first;
                        res.second_data = data;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    assign push_ok = o_take && emit;

    always_comb begin
        n_count = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_running     <= '0;
            r_held_first  <= '0;
            r_held_second <= '0;
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_count       <= '0;
        end else begin
            if (o_take) begin
                r_phase       <= n_phase;
                r_running     <= n_running;
                r_held_first  <= n_held_first;
                r_held_second <= n_held_second;
            end
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_res[r_wr_ptr] <= res;
        end
    end

    assign o_msg_length      = r_res[r_rd_ptr].length;
    assign o_msg_status      = r_res[r_rd_ptr].status;
    assign o_msg_first_data  = r_res[r_rd_ptr].first_data;
    assign o_msg_second_data = r_res[r_rd_ptr].second_data;

    a_res_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue count out of range");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_msg_length != 2'd0 && o_msg_status[7]))
        else $error("result with bad length or status");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_msg_length == LEN_ONE) |->
        (o_msg_first_data == '0 && o_msg_second_data == '0))
        else $error("one-byte message carries data");

    a_three_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_ok && res.length == LEN_THREE) |=> r_phase == PH_FIRST)
        else $error("parser not rearmed after three-byte message");

endmodule

/* src/midi_running_status_parser.sv */
// Path: a transferred byte is written into the front command queue; the back
// parser then writes its message (if any) into the result queue, read at the ports.
// Throughput: one byte per cycle; the parser retires one queued byte per cycle
// as long as the two-entry result queue has room or is popped the same cycle.
// Reset: synchronous, active low; both queues empty, parser idle, running
// status and held data bytes zero.
module midi_running_status_parser
    import mrsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input side, queue style
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_rx_byte,
    // message output side, queue style
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_msg_length,
    output logic [7:0] o_msg_status,
    output logic [6:0] o_msg_first_data,
    output logic [6:0] o_msg_second_data
);

    // classified bytes waiting for the parser
    t_cmd_chan chan;
    // parser takes the head command this cycle
    logic      take;

    // Front: classifies each received byte (data, status with one or two
    // data bytes, real-time, clearing system bytes) and queues it.
    mrsp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_rx_byte (i_rx_byte),
        .o_chan    (chan),
        .i_take    (take)
    );

    // Back: running-status state machine plus held data bytes; completed
    // messages go into a small result queue so the parser keeps moving
    // while a message waits to be popped.
    mrsp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_chan            (chan),
        .o_take            (take),
        .empty             (empty),
        .pop               (pop),
        .o_msg_length      (o_msg_length),
        .o_msg_status      (o_msg_status),
        .o_msg_first_data  (o_msg_first_data),
        .o_msg_second_data (o_msg_second_data)
    );

endmodule
